/* src/acd_pkg.sv */
// Shared types and constants for the argmax class debounce block.
package acd_pkg;

	localparam int unsigned NUM_CLASSES = 8;
	localparam logic [3:0]  CLASS_NONE  = 4'd15;
	localparam logic [7:0]  COUNT_MAX   = 8'd255;

	localparam logic [7:0]         REQ_RESET   = 8'd3;
	localparam logic signed [31:0] FLOOR_RESET = -32'sd65536000;
	localparam logic [3:0]         IDLE_RESET  = 4'd0;

	typedef enum logic [1:0] {
		REG_REQUIRED = 2'd0,
		REG_FLOOR    = 2'd1,
		REG_IDLE     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] score;
		logic [3:0]         class_index;
		logic               frame_last;
		logic               frame_failed;
	} item_t;

	typedef struct packed {
		logic [3:0]         raw_class;
		logic signed [31:0] raw_score;
		logic [3:0]         stable_class;
		logic               gesture_event;
	} result_t;

	// frame close summary from the argmax stage to the debounce stage
	typedef struct packed {
		logic               close;
		logic [3:0]         detected;
		logic signed [31:0] win_score;
	} frame_t;

endpackage

/* src/argmax_class_debounce.sv */
// Top level: frame argmax of class scores with consecutive-frame debounce.
//
//  channel | direction | handshake             | beat
//  item    | in        | item_valid/item_stall | score, class_index, frame_last, frame_failed
//  result  | out       | result_valid/stall    | raw_class, raw_score, stable_class, event
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One item beat is taken every cycle unless item_stall holds it; each beat passes
// an input register and the compare/update logic before its result lands in a two-entry queue.
// A result is valid once the closing beat has passed the input register into the queue.
// Only a good frame close produces a result beat; other beats update state only.
// The item side stalls only while a closing beat waits on a full result queue.
// Reset restores the configuration defaults and clears the argmax and debounce state.
module argmax_class_debounce (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  acd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output acd_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);
	import acd_pkg::*;

	logic [7:0]         required_q;
	logic signed [31:0] floor_q;
	logic [3:0]         idle_q;

	item_t   item_s1;
	logic    valid_s1;
	logic    go;
	logic    full;
	logic    push;
	frame_t  frame;
	result_t push_data;
	logic [3:0] stable_class;
	logic       gesture_event;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_q <= REQ_RESET;
			floor_q    <= FLOOR_RESET;
			idle_q     <= IDLE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_REQUIRED: required_q <= cfg_data[7:0];
				REG_FLOOR:    floor_q    <= cfg_data;
				REG_IDLE:     idle_q     <= cfg_data[3:0];
				default:      ;
			endcase
		end
	end

	// hold the staged beat only when it would produce a result into a full queue
	assign go         = valid_s1 && !(frame.close && full);
	assign item_stall = valid_s1 && !go;
	assign push       = go && frame.close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	acd_argmax u_argmax (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.item_s1 (item_s1),
		.floor   (floor_q),
		.frame   (frame)
	);

	acd_debounce u_debounce (
		.clk           (clk),
		.arst_n        (arst_n),
		.close         (push),
		.detected      (frame.detected),
		.required      (required_q),
		.idle_class    (idle_q),
		.stable_class  (stable_class),
		.gesture_event (gesture_event)
	);

	assign push_data.raw_class     = frame.detected;
	assign push_data.raw_score     = frame.win_score;
	assign push_data.stable_class  = stable_class;
	assign push_data.gesture_event = gesture_event;

	acd_out_queue u_out_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.push_data    (push_data),
		.full         (full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> valid_s1 && $stable(item_s1))
		else $error("staged item beat lost while stalled");

endmodule

/* src/acd_argmax.sv */
// Running argmax over the scores of one frame.
module acd_argmax (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  acd_pkg::item_t       item_s1,
	input  logic signed [31:0]   floor,
	output acd_pkg::frame_t      frame
);
	import acd_pkg::*;

	logic signed [31:0] max_q;
	logic [3:0]         class_q;
	logic               in_range;
	logic signed [31:0] ref_score;
	logic               win;
	logic [3:0]         class_next;
	logic signed [31:0] max_next;

	assign in_range  = ({28'd0, item_s1.class_index} < NUM_CLASSES);
	// until a winner exists, compare with the live floor
	assign ref_score = (class_q == CLASS_NONE) ? floor : max_q;
	assign win       = in_range && (item_s1.score > ref_score);

	assign class_next = win ? item_s1.class_index : class_q;
	assign max_next   = win ? item_s1.score : max_q;

	assign frame.close     = item_s1.frame_last && !item_s1.frame_failed;
	assign frame.detected  = class_next;
	assign frame.win_score = (class_next == CLASS_NONE) ? floor : max_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= CLASS_NONE;
			max_q   <= FLOOR_RESET;
		end else if (go) begin
			if (item_s1.frame_last) begin
				class_q <= CLASS_NONE;
				max_q   <= floor;
			end else begin
				class_q <= class_next;
				max_q   <= max_next;
			end
		end
	end

endmodule

/* src/acd_debounce.sv */
// Consecutive-frame debounce of the frame argmax.
module acd_debounce (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            close,
	input  logic [3:0]      detected,
	input  logic [7:0]      required,
	input  logic [3:0]      idle_class,
	output logic [3:0]      stable_class,
	output logic            gesture_event
);
	import acd_pkg::*;

	logic [3:0] cand_q;
	logic [3:0] confirmed_q;
	logic [7:0] run_q;
	logic [3:0] cand_next;
	logic [7:0] run_next;
	logic       confirm;

	always_comb begin
		if (detected == cand_q) begin
			cand_next = cand_q;
			run_next  = (run_q == COUNT_MAX) ? run_q : run_q + 8'd1;
		end else begin
			cand_next = detected;
			run_next  = 8'd1;
		end
	end

	assign confirm       = (run_next >= required) && (cand_next != confirmed_q);
	assign stable_class  = confirm ? cand_next : confirmed_q;
	assign gesture_event = confirm && (cand_next != idle_class) && (cand_next != CLASS_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q      <= CLASS_NONE;
			confirmed_q <= CLASS_NONE;
			run_q       <= 8'd0;
		end else if (close) begin
			cand_q      <= cand_next;
			run_q       <= run_next;
			confirmed_q <= stable_class;
		end
	end

	a_event_changes: assert property (@(posedge clk) disable iff (!arst_n)
		close && gesture_event |=> confirmed_q != $past(confirmed_q))
		else $error("event without a change of stable class");

endmodule

/* src/acd_out_queue.sv */
// Two-entry result queue that decouples processing from the result stall.
module acd_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  acd_pkg::result_t  push_data,
	output logic              full,
	output logic              result_valid,
	input  logic              result_stall,
	output acd_pkg::result_t  result
);
	import acd_pkg::*;

	result_t    mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full         = (cnt_q == 2'd2);
	assign result_valid = (cnt_q != 2'd0);
	assign result       = mem_q[rd_q];
	assign pop          = result_valid && !result_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full result queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

endmodule
